/* design/qn_pkg.sv */
`timescale 1ns / 1ps
package qn_pkg;
  localparam int COMP_W  = 32;
  localparam int NCOMP   = 4;
  localparam int RAD_W   = 66;
  localparam int ROOT_W  = 33;
  localparam int REM_W   = 35;
  localparam int QUO_W   = 31;
  localparam int DREM_W  = 34;
  localparam int SQRT_CELLS = RAD_W / 2;
  localparam int DIV_CELLS  = QUO_W;
  localparam logic [31:0] MIN_MAG_RESET = 32'd11;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  // register index, byte address is index * 4
  localparam logic [0:0]  REG_MIN_MAG = 1'b0;

  typedef struct packed {
    logic [RAD_W-1:0]                  rad;
    logic [REM_W-1:0]                  rem;
    logic [ROOT_W-1:0]                 root;
    logic [NCOMP-1:0][COMP_W-1:0]      a;
    logic [NCOMP-1:0]                  neg;
  } sq_data_t;

  typedef struct packed {
    logic [ROOT_W-1:0]                 mag;
    logic [NCOMP-1:0][DREM_W-1:0]      r;
    logic [NCOMP-1:0][QUO_W-1:0]       q;
    logic [NCOMP-1:0]                  neg;
  } dv_data_t;
endpackage

/* design/qn_sqrt_cell.sv */
`timescale 1ns / 1ps
module qn_sqrt_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_in,
  input  qn_pkg::sq_data_t d_in,
  output logic             valid_out,
  output qn_pkg::sq_data_t d_out
);
  logic             valid_r;
  qn_pkg::sq_data_t d_r;
  qn_pkg::sq_data_t d_nxt;
  logic [qn_pkg::REM_W-1:0] rem_t;
  logic [qn_pkg::REM_W-1:0] trial;

  // one root bit per cell, two radicand bits consumed
  always_comb begin
    d_nxt = d_in;
    rem_t = {d_in.rem[qn_pkg::REM_W-3:0], d_in.rad[qn_pkg::RAD_W-1 -: 2]};
    trial = {1'b0, d_in.root[qn_pkg::ROOT_W-2:0], 2'b01};
    d_nxt.rad = {d_in.rad[qn_pkg::RAD_W-3:0], 2'b00};
    if (rem_t >= trial) begin
      d_nxt.rem  = rem_t - trial;
      d_nxt.root = {d_in.root[qn_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      d_nxt.rem  = rem_t;
      d_nxt.root = {d_in.root[qn_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign valid_out = valid_r;
  assign d_out     = d_r;
endmodule

/* design/qn_div_cell.sv */
`timescale 1ns / 1ps
module qn_div_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_in,
  input  qn_pkg::dv_data_t d_in,
  output logic             valid_out,
  output qn_pkg::dv_data_t d_out
);
  logic             valid_r;
  qn_pkg::dv_data_t d_r;
  qn_pkg::dv_data_t d_nxt;
  logic [qn_pkg::DREM_W-1:0] diff;

  // one quotient bit per lane, remainder shifted after the compare
  always_comb begin
    d_nxt = d_in;
    diff  = '0;
    for (int i = 0; i < qn_pkg::NCOMP; i++) begin
      if (d_in.r[i] >= {1'b0, d_in.mag}) begin
        diff = d_in.r[i] - {1'b0, d_in.mag};
        d_nxt.q[i] = {d_in.q[i][qn_pkg::QUO_W-2:0], 1'b1};
      end else begin
        diff = d_in.r[i];
        d_nxt.q[i] = {d_in.q[i][qn_pkg::QUO_W-2:0], 1'b0};
      end
      d_nxt.r[i] = {diff[qn_pkg::DREM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign valid_out = valid_r;
  assign d_out     = d_r;
endmodule

/* design/quaternion_normalizer.sv */
`timescale 1ns / 1ps
// Quaternion normalizer: takes one request per cycle while in_stall is low and returns
// one result per request through abs/square/sum stages, one root-bit cell per magnitude
// bit, one quotient-bit cell per quotient bit and an output register.
// The whole pipeline holds while a result waits under out_stall. A magnitude of zero or
// below min_magnitude gives the identity quaternion with out_degenerate set.
module quaternion_normalizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_qx,
  input  logic signed [31:0] in_qy,
  input  logic signed [31:0] in_qz,
  input  logic signed [31:0] in_qw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_nx,
  output logic signed [31:0] out_ny,
  output logic signed [31:0] out_nz,
  output logic signed [31:0] out_nw,
  output logic               out_degenerate,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  localparam int NC = qn_pkg::NCOMP;
  localparam int CW = qn_pkg::COMP_W;

  logic [31:0] min_mag_r;
  logic        en;

  logic                   v0_r, v1_r, v2_r;
  logic [NC-1:0][CW-1:0]  a0_r, a1_r, a2_r;
  logic [NC-1:0]          n0_r, n1_r, n2_r;
  logic [NC-1:0][2*CW-1:0] sq1_r;
  logic [qn_pkg::RAD_W-1:0] sum2_r;
  logic [NC-1:0][CW-1:0]  comp;

  logic             sv [qn_pkg::SQRT_CELLS+1];
  qn_pkg::sq_data_t sd [qn_pkg::SQRT_CELLS+1];
  logic             dv [qn_pkg::DIV_CELLS+1];
  qn_pkg::dv_data_t dd [qn_pkg::DIV_CELLS+1];

  logic              out_valid_r;
  logic [NC-1:0][31:0] n_r, n_nxt;
  logic              degen_r, degen_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == {qn_pkg::REG_MIN_MAG, 2'b00}) ? min_mag_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_mag_r <= qn_pkg::MIN_MAG_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == {qn_pkg::REG_MIN_MAG, 2'b00}) begin
      min_mag_r <= cfg_pwdata;
    end
  end

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign comp = {in_qw, in_qz, in_qy, in_qx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        n0_r[i] <= comp[i][CW-1];
        a0_r[i] <= comp[i][CW-1] ? (~comp[i] + 1'b1) : comp[i];
        sq1_r[i] <= a0_r[i] * a0_r[i];
      end
      a1_r <= a0_r;
      n1_r <= n0_r;
      a2_r <= a1_r;
      n2_r <= n1_r;
      sum2_r <= {2'b00, sq1_r[0]} + {2'b00, sq1_r[1]} + {2'b00, sq1_r[2]} + {2'b00, sq1_r[3]};
    end
  end

  assign sv[0]      = v2_r;
  assign sd[0].rad  = sum2_r;
  assign sd[0].rem  = '0;
  assign sd[0].root = '0;
  assign sd[0].a    = a2_r;
  assign sd[0].neg  = n2_r;

  for (genvar g = 0; g < qn_pkg::SQRT_CELLS; g++) begin : g_sqrt
    qn_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_in(sv[g]), .d_in(sd[g]),
      .valid_out(sv[g+1]), .d_out(sd[g+1])
    );
  end

  assign dv[0]     = sv[qn_pkg::SQRT_CELLS];
  assign dd[0].mag = sd[qn_pkg::SQRT_CELLS].root;
  assign dd[0].q   = '0;
  assign dd[0].neg = sd[qn_pkg::SQRT_CELLS].neg;
  for (genvar g = 0; g < NC; g++) begin : g_rinit
    assign dd[0].r[g] = {2'b00, sd[qn_pkg::SQRT_CELLS].a[g]};
  end

  for (genvar g = 0; g < qn_pkg::DIV_CELLS; g++) begin : g_div
    qn_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_in(dv[g]), .d_in(dd[g]),
      .valid_out(dv[g+1]), .d_out(dd[g+1])
    );
  end

  // magnitude never falls below a component, so the quotient stays within 2^30
  always_comb begin
    qn_pkg::dv_data_t last;
    last = dd[qn_pkg::DIV_CELLS];
    degen_nxt = (last.mag == '0) || (last.mag < {1'b0, min_mag_r});
    for (int i = 0; i < NC; i++) begin
      if (degen_nxt) begin
        n_nxt[i] = (i == NC - 1) ? qn_pkg::ONE_Q30 : 32'd0;
      end else if (last.neg[i]) begin
        n_nxt[i] = ~{1'b0, last.q[i]} + 1'b1;
      end else begin
        n_nxt[i] = {1'b0, last.q[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv[qn_pkg::DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r     <= n_nxt;
      degen_r <= degen_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_nx         = n_r[0];
  assign out_ny         = n_r[1];
  assign out_nz         = n_r[2];
  assign out_nw         = n_r[3];
  assign out_degenerate = degen_r;

  a_degen_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_nx == 0 && out_ny == 0 && out_nz == 0 &&
      out_nw == qn_pkg::ONE_Q30)
    else $error("degenerate result is not the identity");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_nw <= $signed(qn_pkg::ONE_Q30)) && (out_nw >= -$signed(qn_pkg::ONE_Q30)))
    else $error("output component beyond unit range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("request taken while result blocked");
endmodule
